// ===== design/assert_macros.svh =====
// Assertion macros shared by the smoother RTL.
// Plain text macros; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/mws_pkg.sv =====
// Shared types and constants for the masked 3x3 weighted smoother.
// No dependencies.
package mws_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int HEIGHT_BITS = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int FW_W        = 11;               // frame_width register
  localparam int WT_W        = 16;               // Q0.16 weights
  localparam int ORTH_W      = HEIGHT_BITS + 2;  // sum of four heights
  localparam int PB_W        = HEIGHT_BITS + WT_W;
  localparam int PN_W        = ORTH_W + WT_W;
  localparam int SUM_W       = HEIGHT_BITS + WT_W + 4;
  localparam int RES_W       = SUM_W - WT_W;

  localparam int DESC_DEPTH  = 4;
  localparam int DESC_PTR_W  = $clog2(DESC_DEPTH);
  localparam int OUT_DEPTH   = 8;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WT_W-1:0]  BASE_WT_RST   = WT_W'(45875);
  localparam logic [WT_W-1:0]  ORTH_WT_RST   = WT_W'(3277);
  localparam logic [WT_W-1:0]  DIAG_WT_RST   = WT_W'(1638);
  localparam logic [FW_W-1:0]  FRAME_W_RST   = FW_W'(1024);
  localparam logic [ROW_W-1:0] FRAME_H_RST   = ROW_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_WEIGHT   = 3'd0,
    REG_EDGE_WEIGHT   = 3'd1,
    REG_CORNER_WEIGHT = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4
  } mws_reg_e;

  typedef struct packed {
    logic [WT_W-1:0] base_wt;
    logic [WT_W-1:0] orth_wt;
    logic [WT_W-1:0] diag_wt;
  } mws_weights_t;

  typedef struct packed {
    logic [FW_W-1:0]  width;
    logic [ROW_W-1:0] height;
  } mws_size_t;

  // What travels with an item to the output
  typedef struct packed {
    logic             emit;   // item produces a result
    logic             inner;  // emitted cell is not on the border
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } mws_meta_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] sample;
    logic [COL_W-1:0]       addr;
    mws_meta_t              meta;
  } mws_desc_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic                   last;
  } mws_result_t;

endpackage

// ===== design/mws_front.sv =====
// Front end: raster position tracking and item classification.
// Depends on mws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mws_front import mws_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mws_size_t              size_i,
  input  logic                   accept_i,
  input  logic [HEIGHT_BITS-1:0] sample_i,
  input  logic                   frame_start_i,
  output mws_desc_t              desc_o
);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W:0]   row_pre;
  logic [ROW_W:0]   row_inc;
  logic [FW_W-1:0]  c_next;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;

  always_comb begin
    if (size_i.width < FW_W'(3)) begin
      w_eff = FW_W'(3);
    end else if (size_i.width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = size_i.width;
    end
    h_eff = (size_i.height < ROW_W'(3)) ? ROW_W'(3) : size_i.height;
  end

  // Position of this item, then position of the next one
  always_comb begin
    c       = col_q;
    row_pre = {1'b0, row_q};
    if (FW_W'(col_q) >= w_eff) begin
      c       = '0;
      row_pre = {1'b0, row_q} + (ROW_W+1)'(1);
    end
    r = (row_pre >= {1'b0, h_eff}) ? '0 : row_pre[ROW_W-1:0];
    if (frame_start_i) begin
      r = '0;
      c = '0;
    end

    c_next  = FW_W'(c) + FW_W'(1);
    row_inc = {1'b0, r} + (ROW_W+1)'(1);
    if (c_next >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = c_next[COL_W-1:0];
      row_d = r;
    end

    desc_o.sample     = sample_i;
    desc_o.addr       = c;
    desc_o.meta.emit  = (r != '0) && (c != '0);
    desc_o.meta.inner = (r >= ROW_W'(2)) && (c >= COL_W'(2));
    desc_o.meta.row   = r - ROW_W'(1);
    desc_o.meta.col   = c - COL_W'(1);
    desc_o.meta.last  = (r == h_eff - ROW_W'(1)) && (FW_W'(c) == w_eff - FW_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // The final cell of a map is always an interior, emitted cell
  `ASSERT_IMPL(a_last_is_inner, clk_i, rst_ni, accept_i && desc_o.meta.last, desc_o.meta.emit && desc_o.meta.inner, "last cell not an emitted interior cell")

endmodule

// ===== design/mws_desc_queue.sv =====
// Short descriptor queue between the front end and the filter back end.
// Depends on mws_pkg.
module mws_desc_queue import mws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  mws_desc_t wr_data_i,
  output logic      full_o,
  input  logic      rd_en_i,
  output mws_desc_t rd_data_o,
  output logic      empty_o
);

  mws_desc_t             mem_q [DESC_DEPTH];
  logic [DESC_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [DESC_PTR_W:0]   cnt_q;

  assign full_o    = (cnt_q == (DESC_PTR_W+1)'(DESC_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) wr_ptr_q <= wr_ptr_q + DESC_PTR_W'(1);
      if (rd_en_i) rd_ptr_q <= rd_ptr_q + DESC_PTR_W'(1);
      unique case ({wr_en_i, rd_en_i})
        2'b10:   cnt_q <= cnt_q + (DESC_PTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (DESC_PTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== design/mws_back.sv =====
// Back end: line buffers, 3x3 window, weighted sum pipeline, result queue.
// Depends on mws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mws_back import mws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mws_weights_t weights_i,
  input  mws_desc_t    desc_i,
  input  logic         desc_empty_i,
  output logic         desc_pop_o,
  output mws_result_t  result_o,
  output logic         empty_o,
  input  logic         pop_i
);

  // Line buffers
  logic [HEIGHT_BITS-1:0] above_mem [MAX_WIDTH];
  logic [HEIGHT_BITS-1:0] two_mem   [MAX_WIDTH];

  // Stage 1: buffer read data, write-collision bypass
  logic                   s1_v_q;
  mws_desc_t              s1_q;
  mws_meta_t              s1_meta;
  logic [HEIGHT_BITS-1:0] above_rd_q, two_rd_q;
  logic                   fwd_q;
  logic [HEIGHT_BITS-1:0] fwd_above_q, fwd_two_q;
  logic [HEIGHT_BITS-1:0] win_q [6];  // 0..2 column c-1 top/mid/bot, 3..5 column c-2
  logic [HEIGHT_BITS-1:0] top, mid, bot;
  logic [ORTH_W-1:0]      orth, diag;

  // Stage 2: sums
  logic                   s2_v_q;
  mws_meta_t              s2_meta_q;
  logic [HEIGHT_BITS-1:0] centre_q;
  logic [ORTH_W-1:0]      orth_q, diag_q;

  // Stage 3: products
  logic                   s3_v_q;
  mws_meta_t              s3_meta_q;
  logic [PB_W-1:0]        prod_b_q;
  logic [PN_W-1:0]        prod_o_q, prod_d_q;
  logic [SUM_W-1:0]       sum;
  logic [RES_W-1:0]       res;
  mws_result_t            res_item;

  // Result queue
  mws_result_t            out_mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   out_wr_q, out_rd_q;
  logic [OUT_PTR_W:0]     out_cnt_q;
  logic [1:0]             inflight;
  logic [OUT_PTR_W:0]     occupancy;
  logic                   issue, collide, out_push, out_pop;

  // Issue only when every item in flight still has a result slot
  assign inflight  = 2'(s1_v_q) + 2'(s2_v_q) + 2'(s3_v_q);
  assign occupancy = out_cnt_q + (OUT_PTR_W+1)'(inflight);
  assign issue     = !desc_empty_i && (occupancy < (OUT_PTR_W+1)'(OUT_DEPTH));
  assign desc_pop_o = issue;
  assign collide   = issue && s1_v_q && (s1_q.addr == desc_i.addr);

  always_comb begin
    mid  = fwd_q ? fwd_above_q : above_rd_q;
    top  = fwd_q ? fwd_two_q   : two_rd_q;
    bot  = s1_q.sample;
    orth = ORTH_W'(win_q[0]) + ORTH_W'(win_q[2]) + ORTH_W'(win_q[4]) + ORTH_W'(mid);
    diag = ORTH_W'(win_q[3]) + ORTH_W'(win_q[5]) + ORTH_W'(top) + ORTH_W'(bot);
    // zero centre forces a 0 result, same as a border cell
    s1_meta       = s1_q.meta;
    s1_meta.inner = s1_q.meta.inner && (win_q[1] != '0);
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) above_mem[s1_q.addr] <= s1_q.sample;
    if (issue)  above_rd_q <= above_mem[desc_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) two_mem[s1_q.addr] <= mid;
    if (issue)  two_rd_q <= two_mem[desc_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      fwd_q     <= 1'b0;
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (issue) fwd_q <= collide;
      if (s1_v_q) begin
        win_q[3] <= win_q[0];
        win_q[4] <= win_q[1];
        win_q[5] <= win_q[2];
        win_q[0] <= top;
        win_q[1] <= mid;
        win_q[2] <= bot;
      end
      if (out_push) out_wr_q <= out_wr_q + OUT_PTR_W'(1);
      if (out_pop)  out_rd_q <= out_rd_q + OUT_PTR_W'(1);
      unique case ({out_push, out_pop})
        2'b10:   out_cnt_q <= out_cnt_q + (OUT_PTR_W+1)'(1);
        2'b01:   out_cnt_q <= out_cnt_q - (OUT_PTR_W+1)'(1);
        default: out_cnt_q <= out_cnt_q;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q        <= desc_i;
      fwd_above_q <= s1_q.sample;
      fwd_two_q   <= mid;
    end
    if (s1_v_q) begin
      s2_meta_q <= s1_meta;
      centre_q  <= win_q[1];
      orth_q    <= orth;
      diag_q    <= diag;
    end
    if (s2_v_q) begin
      s3_meta_q <= s2_meta_q;
      prod_b_q  <= PB_W'(centre_q) * PB_W'(weights_i.base_wt);
      prod_o_q  <= PN_W'(orth_q) * PN_W'(weights_i.orth_wt);
      prod_d_q  <= PN_W'(diag_q) * PN_W'(weights_i.diag_wt);
    end
    if (out_push) out_mem_q[out_wr_q] <= res_item;
  end

  // Truncate back to Q8.8, saturate, zero the border and zero-centre cells
  always_comb begin
    sum = SUM_W'(prod_b_q) + SUM_W'(prod_o_q) + SUM_W'(prod_d_q);
    res = sum[SUM_W-1:WT_W];
    res_item.height = '0;
    if (s3_meta_q.inner) begin
      res_item.height = (res[RES_W-1:HEIGHT_BITS] != '0) ? '1 : res[HEIGHT_BITS-1:0];
    end
    res_item.row  = s3_meta_q.row;
    res_item.col  = s3_meta_q.col;
    res_item.last = s3_meta_q.last;
  end

  assign out_push = s3_v_q && s3_meta_q.emit;
  assign out_pop  = pop_i && !empty_o;
  assign empty_o  = (out_cnt_q == '0);
  assign result_o = out_mem_q[out_rd_q];

  `ASSERT_IMPL(a_out_no_overflow, clk_i, rst_ni, out_push, out_cnt_q < (OUT_PTR_W+1)'(OUT_DEPTH), "result queue overflow")
  `ASSERT_ALWAYS(a_credit_bound, clk_i, rst_ni, occupancy <= (OUT_PTR_W+1)'(OUT_DEPTH), "in-flight items exceed result slots")
  `ASSERT_IMPL(a_bypass_col0, clk_i, rst_ni, s1_v_q && fwd_q, s1_q.addr == '0, "buffer bypass away from column 0")

endmodule

// ===== design/masked_3x3_weighted_smoother.sv =====
// Top level of the masked 3x3 weighted smoother: configuration registers,
// front end, descriptor queue and filter back end. Depends on mws_pkg.
//
// Streams a height map (unsigned Q8.8, raster order) and, once input (r, c)
// arrives, delivers cell (r-1, c-1) as
// (centre*base + edge*(N+S+W+E) + corner*(NW+NE+SW+SE)) >> 16, saturated to
// 16 bits; border cells and cells with a zero centre come out as 0. Inputs
// in row 0 or column 0 produce no result, so the last row and column of a
// map never appear. Rate: one item per clock sustained, input and output, as
// long as results are popped; a full result queue holds the input back. Each
// result reaches the output queue through the descriptor queue, the bypassed
// line-buffer read, the window/sum stage and the three parallel multipliers;
// the final add-and-saturate sits in front of the result queue write. The line
// buffers hold stale data after reset; only row-0 border cells read it.
// Configuration is taken every cycle (cfg_ready_o is tied high) and must be
// written while no item is in flight; unknown register indexes are dropped.
module masked_3x3_weighted_smoother import mws_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input item queue side
  input  logic                   push,
  output logic                   full,
  input  logic [HEIGHT_BITS-1:0] height_sample_i,
  input  logic                   frame_start_i,
  // result queue side
  output logic                   empty,
  input  logic                   pop,
  output logic [HEIGHT_BITS-1:0] smoothed_height_o,
  output logic [ROW_W-1:0]       out_row_o,
  output logic [COL_W-1:0]       out_col_o,
  output logic                   frame_last_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  mws_weights_t weights_q;
  mws_size_t    size_q;
  mws_desc_t    front_desc, queue_head;
  mws_result_t  result;
  logic         accept, queue_empty, desc_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q.base_wt <= BASE_WT_RST;
      weights_q.orth_wt <= ORTH_WT_RST;
      weights_q.diag_wt <= DIAG_WT_RST;
      size_q.width      <= FRAME_W_RST;
      size_q.height     <= FRAME_H_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mws_reg_e'(cfg_index_i))
        REG_BASE_WEIGHT:   weights_q.base_wt <= cfg_data_i[WT_W-1:0];
        REG_EDGE_WEIGHT:   weights_q.orth_wt <= cfg_data_i[WT_W-1:0];
        REG_CORNER_WEIGHT: weights_q.diag_wt <= cfg_data_i[WT_W-1:0];
        REG_FRAME_WIDTH:   size_q.width      <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT:  size_q.height     <= cfg_data_i[ROW_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // Input transfer: push while not full
  assign accept = push && !full;

  mws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .size_i        (size_q),
    .accept_i      (accept),
    .sample_i      (height_sample_i),
    .frame_start_i (frame_start_i),
    .desc_o        (front_desc)
  );

  // Decouples position tracking from the filter pipeline
  mws_desc_queue u_desc_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (front_desc),
    .full_o    (full),
    .rd_en_i   (desc_pop),
    .rd_data_o (queue_head),
    .empty_o   (queue_empty)
  );

  mws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .weights_i    (weights_q),
    .desc_i       (queue_head),
    .desc_empty_i (queue_empty),
    .desc_pop_o   (desc_pop),
    .result_o     (result),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  assign smoothed_height_o = result.height;
  assign out_row_o         = result.row;
  assign out_col_o         = result.col;
  assign frame_last_o      = result.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the masked 3x3 weighted smoother: directed table then random maps.
// Depends on mws_pkg and masked_3x3_weighted_smoother; predicts every result itself.
module tb_top import mws_pkg::*; ();

  localparam int MIN_SIZE      = 3;     // smallest map side the block accepts
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
  localparam int RANDOM_CELLS  = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = '1;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

  // fixed setups of the first random phases
  localparam int PHASE_CLAMP_LOW  = 0;  // zero weights, sizes below the minimum
  localparam int PHASE_SATURATE   = 1;  // full-scale weights, tallest map
  localparam int PHASE_WIDE_FRAME = 2;  // oversized width and zero height, both clamped
  localparam int PHASE_FULL_WIDTH = 3;  // exact maximum width

  typedef enum logic {STEP_CELL, STEP_WRITE} step_e;

  typedef struct packed {
    step_e                  kind;
    logic [CFG_IDX_W-1:0]   idx;    // register, writes only
    logic [CFG_DATA_W-1:0]  value;  // sample or register data
    logic                   start;
    logic                   typed;  // expected height written out below
    logic [HEIGHT_BITS-1:0] want;
  } plan_row_t;

  localparam int PLAN_ROWS = 31;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // reset setup (1024 wide): row 0 only, nothing comes out
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h1234, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h8000, 1'b0, 1'b0, 16'h0000},
    // shrink to 3x3 while sitting at column 4; unknown index is dropped
    '{STEP_WRITE, REG_FRAME_WIDTH,   16'd3,    1'b0, 1'b0, 16'h0000},
    '{STEP_WRITE, REG_FRAME_HEIGHT,  16'd3,    1'b0, 1'b0, 16'h0000},
    '{STEP_WRITE, REG_UNUSED,        16'hFFFF, 1'b0, 1'b0, 16'h0000},
    // position jumps to (1, 0); the two results are border cells
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h00FF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h0101, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h7FFF, 1'b0, 1'b1, 16'h0000},
    '{STEP_WRITE, REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_WRITE, REG_EDGE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_WRITE, REG_CORNER_WEIGHT, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    // all-max 3x3 map: the one interior cell saturates
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
    // next map follows the wrap without frame_start; zero centre gives 0
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'h0000, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'h0000},
    '{STEP_CELL,  REG_BASE_WEIGHT,   16'hFFFF, 1'b0, 1'b1, 16'h0000}
  };

  // ports; every input is known from time 0
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [HEIGHT_BITS-1:0] height_sample_i = '0;
  logic                   frame_start_i = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [HEIGHT_BITS-1:0] smoothed_height_o;
  logic [ROW_W-1:0]       out_row_o;
  logic [COL_W-1:0]       out_col_o;
  logic                   frame_last_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // predictor copy of the block state and registers
  logic [HEIGHT_BITS-1:0] row_above     [MAX_WIDTH];
  logic [HEIGHT_BITS-1:0] row_two_above [MAX_WIDTH];
  logic [HEIGHT_BITS-1:0] win_cells     [6];  // 0..2 column c-1 top..bot, 3..5 column c-2
  int unsigned            cur_row, cur_col;
  logic [WT_W-1:0]        centre_wt, edge_wt, corner_wt;
  logic [FW_W-1:0]        width_reg;
  logic [ROW_W-1:0]       height_reg;

  mws_result_t            pending_cells[$];  // predicted results, oldest first
  mws_result_t            want_cell;
  int unsigned            fail_count = 0;
  int unsigned            quiet_cycles = 0;
  int unsigned            rx_hold = 0;
  bit                     tx_calm = 1'b0;
  bit                     rx_calm = 1'b0;

  masked_3x3_weighted_smoother dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned map_width();
    if (width_reg < MIN_SIZE) return MIN_SIZE;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned map_height();
    return (height_reg < MIN_SIZE) ? MIN_SIZE : 32'(height_reg);
  endfunction

  function automatic void note_register(input logic [CFG_IDX_W-1:0]  idx,
                                        input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_BASE_WEIGHT:   centre_wt = val;
      REG_EDGE_WEIGHT:   edge_wt = val;
      REG_CORNER_WEIGHT: corner_wt = val;
      REG_FRAME_WIDTH:   width_reg = val[FW_W-1:0];
      REG_FRAME_HEIGHT:  height_reg = val;
      default: ;  // unknown index: no effect
    endcase
  endfunction

  // Advances the predictor by one input cell; returns 1 with the emitted cell
  // when the input is past row 0 and column 0.
  function automatic bit smooth_cell(input  logic [HEIGHT_BITS-1:0] sample,
                                     input  logic                   start,
                                     output mws_result_t            emitted);
    int unsigned       w, h, r, c;
    logic [HEIGHT_BITS-1:0] top, mid;
    longint unsigned   centre, orth, diag, acc;
    bit                emits;
    w = map_width();
    h = map_height();
    emits = 1'b0;
    emitted = '0;
    // a shrunken size can leave the position outside the map
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    if (start) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    top = row_two_above[c];
    mid = row_above[c];
    if (r >= 1 && c >= 1) begin
      emits = 1'b1;
      emitted.row = ROW_W'(r - 1);
      emitted.col = COL_W'(c - 1);
      emitted.last = (r == h - 1) && (c == w - 1);
      centre = 64'(win_cells[1]);
      // border cells and zero centres stay at 0
      if (r >= 2 && c >= 2 && centre != 0) begin
        orth = longint'(win_cells[0]) + win_cells[2] + win_cells[4] + mid;
        diag = longint'(win_cells[3]) + win_cells[5] + top + sample;
        acc = (centre * centre_wt + orth * edge_wt + diag * corner_wt) >> WT_W;
        emitted.height = (acc > HEIGHT_MAX) ? HEIGHT_MAX : HEIGHT_BITS'(acc);
      end
    end
    win_cells[3] = win_cells[0];
    win_cells[4] = win_cells[1];
    win_cells[5] = win_cells[2];
    win_cells[0] = top;
    win_cells[1] = mid;
    win_cells[2] = sample;
    row_two_above[c] = mid;
    row_above[c] = sample;
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end
    return emits;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0, 1:    return '0;
      2:       return '1;
      default: return HEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // One cell transfer; push stays high afterwards unless the caller drops it.
  task automatic send_cell(input logic [HEIGHT_BITS-1:0] sample, input logic start,
                           input logic typed, input logic [HEIGHT_BITS-1:0] want);
    mws_result_t predicted;
    push <= 1'b1;
    height_sample_i <= sample;
    frame_start_i <= start;
    do @(posedge clk_i); while (full);
    if (smooth_cell(sample, start, predicted)) begin
      if (typed) predicted.height = want;
      pending_cells.push_back(predicted);
    end
  endtask

  task automatic tx_pause();
    int unsigned n;
    n = tx_calm ? 0 : pick_gap();
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Block idle: every result out, then the pipeline given time to empty
  // of cells that make no result.
  task automatic drain_block();
    push <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // valid stays high for back-to-back writes; the caller drops it
  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    note_register(idx, val);
  endtask

  // Sets up one random phase. restart asks for frame_start on the first cell
  // when the map got wider, so no never-written buffer entry reaches an
  // interior cell.
  task automatic configure_phase(input int unsigned phase, output bit restart);
    int unsigned old_w;
    logic [CFG_DATA_W-1:0] val;
    old_w = map_width();
    case (phase)
      PHASE_CLAMP_LOW: begin
        write_register(REG_BASE_WEIGHT, '0);
        write_register(REG_EDGE_WEIGHT, '0);
        write_register(REG_CORNER_WEIGHT, '0);
        write_register(REG_FRAME_WIDTH, '0);
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(MIN_SIZE - 1));
      end
      PHASE_SATURATE: begin
        write_register(REG_BASE_WEIGHT, '1);
        write_register(REG_EDGE_WEIGHT, '1);
        write_register(REG_CORNER_WEIGHT, '1);
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(MIN_SIZE));
        write_register(REG_FRAME_HEIGHT, '1);
      end
      PHASE_WIDE_FRAME: begin
        write_register(REG_BASE_WEIGHT, pick_weight());
        write_register(REG_EDGE_WEIGHT, pick_weight());
        write_register(REG_CORNER_WEIGHT, pick_weight());
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'({FW_W{1'b1}}));  // clamps to max
        write_register(REG_FRAME_HEIGHT, '0);                         // clamps to min
      end
      PHASE_FULL_WIDTH: write_register(REG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH));
      default: begin
        if ($urandom_range(0, 1)) write_register(REG_BASE_WEIGHT, pick_weight());
        if ($urandom_range(0, 1)) write_register(REG_EDGE_WEIGHT, pick_weight());
        if ($urandom_range(0, 1)) write_register(REG_CORNER_WEIGHT, pick_weight());
        if ($urandom_range(0, 1)) begin
          val = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, MIN_SIZE - 1))
                                            : CFG_DATA_W'($urandom_range(MIN_SIZE, 12));
          write_register(REG_FRAME_WIDTH, val);
        end
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 7))
            0:       val = CFG_DATA_W'($urandom_range(0, MIN_SIZE - 1));
            1:       val = '1;
            default: val = CFG_DATA_W'($urandom_range(MIN_SIZE, 8));
          endcase
          write_register(REG_FRAME_HEIGHT, val);
        end
        if ($urandom_range(0, 5) == 0)
          write_register(CFG_IDX_W'($urandom_range(REG_UNUSED, REG_TOP)),
                         CFG_DATA_W'($urandom));
      end
    endcase
    cfg_valid_i <= 1'b0;
    restart = map_width() > old_w;
  endtask

  // result side: random pop stalls, none in calm stretches
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
      rx_hold = pick_gap();
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected result: smoothed_height %0d at row %0d col %0d",
               smoothed_height_o, out_row_o, out_col_o);
        fail_count++;
      end else begin
        want_cell = pending_cells.pop_front();
        if (smoothed_height_o !== want_cell.height) begin
          $error("smoothed_height: expected %0d, got %0d", want_cell.height, smoothed_height_o);
          fail_count++;
        end
        if (out_row_o !== want_cell.row) begin
          $error("out_row: expected %0d, got %0d", want_cell.row, out_row_o);
          fail_count++;
        end
        if (out_col_o !== want_cell.col) begin
          $error("out_col: expected %0d, got %0d", want_cell.col, out_col_o);
          fail_count++;
        end
        if (frame_last_o !== want_cell.last) begin
          $error("frame_last: expected %0d, got %0d", want_cell.last, frame_last_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned count;
    bit          restart;
    logic        start;
    // predictor after reset; unwritten line buffer entries read as zero
    centre_wt = BASE_WT_RST;
    edge_wt = ORTH_WT_RST;
    corner_wt = DIAG_WT_RST;
    width_reg = FRAME_W_RST;
    height_reg = FRAME_H_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i] = '0;
      row_two_above[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cells[i] = '0;
    cur_row = 0;
    cur_col = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; writes only once the block is idle
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (DIRECTED_PLAN[i].kind == STEP_WRITE) begin
        if (i == 0 || DIRECTED_PLAN[i - 1].kind == STEP_CELL) drain_block();
        write_register(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].value);
      end else begin
        if (i != 0 && DIRECTED_PLAN[i - 1].kind == STEP_WRITE) cfg_valid_i <= 1'b0;
        send_cell(DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].start,
                  DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        tx_pause();
      end
    end

    // random phases: fresh setup, then a stream of cells with occasional
    // frame_start
    phase = 0;
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      drain_block();
      configure_phase(phase, restart);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase == PHASE_FULL_WIDTH) count = 20;
      else count = $urandom_range(30, 80);
      for (int i = 0; i < count; i++) begin
        start = (i == 0 && restart) || ($urandom_range(0, 39) == 0);
        send_cell(pick_sample(), start, 1'b0, '0);
        tx_pause();
      end
      sent += count;
      phase++;
    end

    drain_block();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mws_pkg.sv
design/mws_front.sv
design/mws_desc_queue.sv
design/mws_back.sv
design/masked_3x3_weighted_smoother.sv
test/tb_top.sv
